### src/sds_pkg.sv
package sds_pkg;

	localparam int unsigned METRIC_COUNT = 8;
	localparam int unsigned INDEX_W = 3;

	// action codes
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_DISCONNECT = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [7:0] STATUS_NONE = 8'd0;
	localparam logic [7:0] STATUS_WAIT = 8'd255;

	localparam logic [INDEX_W-1:0] IDX_UTILITY = 3'd2;
	// runtime, batt mV, load, in mV, out mV carry their own valid mark
	localparam logic [METRIC_COUNT-1:0] FLAGGED_MASK = 8'hF2;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic [2:0]  metric_index;
		logic        metric_present;
		logic [31:0] metric_value;
		logic [7:0]  status_code;
		logic [15:0] hold_ms;
		logic        valid_in;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        read_valid;
		logic [7:0]  committed_status;
		logic        data_valid;
		logic [31:0] update_age_ms;
	} rsp_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        read_valid;
		logic        data_valid;
		logic [31:0] update_age_ms;
	} metric_view_t;

endpackage

### src/sds_debounce.sv
module sds_debounce import sds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  req_t       item,
	output logic [7:0] status_next
);

	logic [7:0]  status_q, cand_q;
	logic [31:0] since_q;
	logic [15:0] hold_q;

	logic [7:0]  status_n, cand_n;
	logic [31:0] since_n;
	logic [15:0] hold_n;
	logic [31:0] elapsed;

	assign elapsed = item.now_ms - since_q;

	always_comb begin
		status_n = status_q;
		cand_n = cand_q;
		since_n = since_q;
		hold_n = hold_q;
		if (item.action == ACT_DISCONNECT) begin
			status_n = STATUS_WAIT;
			cand_n = STATUS_NONE;
			since_n = '0;
			hold_n = '0;
		end else if (item.action == ACT_UPDATE && item.status_code != STATUS_NONE) begin
			if (item.status_code == status_q) begin
				cand_n = STATUS_NONE;
				since_n = '0;
				hold_n = '0;
			end else if (item.hold_ms == '0) begin
				status_n = item.status_code;
				cand_n = STATUS_NONE;
				since_n = '0;
				hold_n = '0;
			end else if (item.status_code == cand_q) begin
				// wrapping time: elapsed is taken modulo 2^32
				if (elapsed >= {16'd0, hold_q}) begin
					status_n = item.status_code;
					cand_n = STATUS_NONE;
					since_n = '0;
					hold_n = '0;
				end
			end else begin
				cand_n = item.status_code;
				since_n = item.now_ms;
				hold_n = item.hold_ms;
			end
		end
	end

	assign status_next = status_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= STATUS_NONE;
			cand_q <= STATUS_NONE;
			since_q <= '0;
			hold_q <= '0;
		end else if (fire) begin
			status_q <= status_n;
			cand_q <= cand_n;
			since_q <= since_n;
			hold_q <= hold_n;
		end
	end

endmodule

### src/sds_metrics.sv
module sds_metrics import sds_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  req_t         item,
	output metric_view_t view
);

	logic [31:0]             metric_q [METRIC_COUNT];
	logic [METRIC_COUNT-1:0] marks_q;
	logic                    overall_q;
	logic [31:0]             last_q;

	logic [METRIC_COUNT-1:0] sel;
	logic [31:0]             wr_value;
	logic                    is_update, is_disc, do_write;
	logic [METRIC_COUNT-1:0] marks_n;
	logic                    overall_n;
	logic [31:0]             last_n;
	logic [31:0]             value_n;

	assign sel = METRIC_COUNT'(1) << item.metric_index;
	assign is_update = (item.action == ACT_UPDATE);
	assign is_disc = (item.action == ACT_DISCONNECT);
	assign do_write = is_update && item.metric_present;
	assign wr_value = (item.metric_index == IDX_UTILITY) ?
		{31'd0, |item.metric_value} : item.metric_value;

	always_comb begin
		marks_n = marks_q;
		overall_n = overall_q;
		last_n = last_q;
		value_n = metric_q[item.metric_index];
		if (is_disc) begin
			marks_n = '0;
			overall_n = 1'b0;
			last_n = item.now_ms;
			value_n = '0;
		end else if (is_update) begin
			if (item.metric_present) begin
				marks_n = marks_q | (sel & FLAGGED_MASK);
				value_n = wr_value;
			end
			overall_n = overall_q | item.valid_in;
			last_n = item.now_ms;
		end
	end

	always_comb begin
		view.read_value = value_n;
		view.read_valid = ((FLAGGED_MASK & sel) == '0) || ((marks_n & sel) != '0);
		view.data_valid = overall_n;
		view.update_age_ms = (item.now_ms >= last_n) ? (item.now_ms - last_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < METRIC_COUNT; i++) begin
				metric_q[i] <= '0;
			end
			marks_q <= '0;
			overall_q <= 1'b0;
			last_q <= '0;
		end else if (fire) begin
			for (int i = 0; i < METRIC_COUNT; i++) begin
				if (is_disc) begin
					metric_q[i] <= '0;
				end else if (do_write && sel[i]) begin
					metric_q[i] <= wr_value;
				end
			end
			marks_q <= marks_n;
			overall_q <= overall_n;
			last_q <= last_n;
		end
	end

endmodule

### src/status_debounce_state_store.sv
// Each item goes through the input register, then through the state update
// into the result register.
// Throughput: one item per cycle; req_stall rises only while the result
// register is full and stalled and the input register also holds an item.
// Reset (arst_n low): both pipeline stages empty, all metrics, marks, the
// candidate and the committed status cleared to zero.
module status_debounce_state_store import sds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	// response channel
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// stage 1: registered item
	logic valid_s1;
	req_t req_s1;
	// stage 2: registered result
	logic valid_s2;
	rsp_t rsp_s2;

	logic         adv2;   // result register can take a new result
	logic         fire;   // stage 1 item is applied to the state this cycle
	logic [7:0]   status_next;
	metric_view_t view;

	assign adv2 = !valid_s2 || !rsp_stall;
	assign fire = valid_s1 && adv2;
	assign req_stall = valid_s1 && !adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// debounced status: committed code plus pending candidate
	sds_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (req_s1),
		.status_next (status_next)
	);

	// metric store, valid marks, overall valid and update time
	sds_metrics u_metrics (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (req_s1),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	// result shows the state after the item
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_s2.read_value <= view.read_value;
			rsp_s2.read_valid <= view.read_valid;
			rsp_s2.committed_status <= status_next;
			rsp_s2.data_valid <= view.data_valid;
			rsp_s2.update_age_ms <= view.update_age_ms;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

endmodule

### src/sds_checker.sv
module sds_checker import sds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// requests back up only behind a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with empty result register");

	// every accepted item is followed by a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |-> ##2 rsp_valid)
		else $error("no result two cycles after accept");

	// a stall can only last while the downstream side keeps stalling
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall && !rsp_stall |=> !req_stall)
		else $error("request stall held after result taken");

endmodule

bind status_debounce_state_store sds_checker u_sds_checker (.*);
